// File: src/fka_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fka_pkg
// shared constants, types and cell coefficients of the arm kinematics block
// ----------------------------------------------------------------------------
package fka_pkg;

    // trig word width, one sign bit and TRIG_BITS-1 fraction bits
    localparam int TRIG_BITS = 16;
    localparam int FRAC      = TRIG_BITS - 1;
    localparam int RND_SH    = 31 - TRIG_BITS;
    localparam logic [31:0] RND_HALF = 32'(1) << (RND_SH - 1);
    localparam logic [31:0] TRIG_MAX = (32'(1) << FRAC) - 32'(1);

    // angle units, 1/128 degree
    localparam int FULL_TURN    = 46080;
    localparam int QUARTER_TURN = 11520;
    localparam int EIGHTH_TURN  = 5760;

    // degrees*128 to radians in Q30, scaled by 2^20
    localparam logic [37:0] RAD_K50  = 38'd153520784550;
    localparam logic [50:0] RAD_HALF = 51'(1) << 19;
    localparam logic [30:0] Q30_ONE  = 31'(1) << 30;

    // horner cells, one per series term
    localparam int NUM_CELLS = 6;
    localparam int CELL_LAT  = 3;
    localparam int AUX_DLY   = 1 + CELL_LAT * NUM_CELLS;
    localparam int TRIG_LAT  = 6 + CELL_LAT * NUM_CELLS;

    // exact reciprocal of each divisor: floor(v/d) = (v*mult) >> shift for v < 2^30
    // cos divisors 132 90 56 30 12 2
    localparam logic [30:0] COS_MULT [NUM_CELLS] = '{
        31'd2082408386, 31'd1527099484, 31'd1227133514,
        31'd1145324613, 31'd1431655766, 31'd1073741824
    };
    localparam logic [5:0] COS_SHIFT [NUM_CELLS] = '{
        6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31
    };
    // sin divisors 110 72 42 20 6, first cell slot unused
    localparam logic [30:0] SIN_MULT [NUM_CELLS] = '{
        31'd0, 31'd1249445032, 31'd1908874354,
        31'd1636178018, 31'd1717986919, 31'd1431655766
    };
    localparam logic [5:0] SIN_SHIFT [NUM_CELLS] = '{
        6'd0, 6'd37, 6'd37, 6'd36, 6'd35, 6'd33
    };

    // arm datapath widths
    localparam int LEN_W  = 16;
    localparam int POS_OW = 19;
    localparam int PROD_W = TRIG_BITS + LEN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int POS_W  = SUM_W + TRIG_BITS;

    // register indexes
    localparam logic [1:0] REG_FIRST_LINK  = 2'd0;
    localparam logic [1:0] REG_SECOND_LINK = 2'd1;
    localparam logic [1:0] REG_THIRD_LINK  = 2'd2;
    localparam logic [LEN_W-1:0] LINK_RESET = 16'd2560;

    // side data that travels with the series evaluation
    typedef struct packed {
        logic [29:0] x;
        logic        swap;
        logic [1:0]  quad;
    } t_trig_aux;

endpackage
`default_nettype wire

// File: src/three_joint_arm_forward_kinematics.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// three_joint_arm_forward_kinematics
// end-effector position of a yaw-pitch-pitch arm from three joint angles
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the output is not stalled; the six-cell
//   horner chains of the three trig units all advance together
// a stall on the output freezes the whole pipeline, nothing is dropped
// reset: synchronous active low, clears the valid pipeline and loads 2560
//   into each link length register
module three_joint_arm_forward_kinematics (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // angle input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_yaw_angle,
    input  wire logic signed [15:0] i_first_pitch_angle,
    input  wire logic signed [15:0] i_second_pitch_angle,
    // position output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [18:0]      o_pos_x,
    output logic signed [18:0]      o_pos_y,
    output logic signed [18:0]      o_pos_z,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int TB    = fka_pkg::TRIG_BITS;
    localparam int LW    = fka_pkg::LEN_W;
    localparam int PW    = fka_pkg::PROD_W;
    localparam int SW    = fka_pkg::SUM_W;
    localparam int QW    = fka_pkg::POS_W;
    localparam int OW    = fka_pkg::POS_OW;
    localparam int F     = fka_pkg::FRAC;
    // trig stages plus the three arm stages before the output register
    localparam int VLD_N = fka_pkg::TRIG_LAT + 3;

    // link length registers
    logic [LW-1:0] r_len1, r_len2, r_len3;
    logic          w_wr;

    // pipeline control: everything moves when the output register frees up
    logic          w_en;
    logic [VLD_N-1:0] r_vld;
    logic          r_out_valid;

    // trig outputs
    logic signed [TB-1:0] w_sy, w_cy, w_s1, w_c1, w_s12, w_c12;
    logic signed [16:0]   w_sum_ang;

    // arm stages
    logic signed [PW-1:0] r_m1, r_m2, r_m3, r_m4;
    logic signed [TB-1:0] r_sy_a, r_cy_a, r_sy_b, r_cy_b;
    logic signed [SW-1:0] r_r, r_zs;
    logic signed [QW-1:0] r_px, r_py;
    logic signed [OW-1:0] r_pz, n_pz;
    logic        [SW:0]   w_zmag, w_zrnd;
    logic        [QW:0]   w_xmag, w_ymag, w_xrnd, w_yrnd;
    logic signed [OW-1:0] n_out_x, n_out_y;
    logic signed [OW-1:0] r_out_x, r_out_y, r_out_z;

    // ------------------------------------------------------------------
    // register port, zero wait state
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= fka_pkg::LINK_RESET;
            r_len2 <= fka_pkg::LINK_RESET;
            r_len3 <= fka_pkg::LINK_RESET;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                fka_pkg::REG_FIRST_LINK:  r_len1 <= pwdata[LW-1:0];
                fka_pkg::REG_SECOND_LINK: r_len2 <= pwdata[LW-1:0];
                fka_pkg::REG_THIRD_LINK:  r_len3 <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fka_pkg::REG_FIRST_LINK:  prdata = 32'(r_len1);
            fka_pkg::REG_SECOND_LINK: prdata = 32'(r_len2);
            fka_pkg::REG_THIRD_LINK:  prdata = 32'(r_len3);
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // flow control: a global enable stalls every stage when the held
    // result is not taken, so a new transaction is taken whenever the
    // output register is empty or draining
    // ------------------------------------------------------------------
    assign w_en       = ~r_out_valid | i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[VLD_N-2:0], i_in_valid};
            r_out_valid <= r_vld[VLD_N-1];
        end
    end

    // ------------------------------------------------------------------
    // three trig units: yaw, first pitch, and the summed pitch
    // ------------------------------------------------------------------
    assign w_sum_ang = 17'(i_first_pitch_angle) + 17'(i_second_pitch_angle);

    fka_trig u_trig_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (17'(i_yaw_angle)),
        .o_sin (w_sy),
        .o_cos (w_cy)
    );

    fka_trig u_trig_p1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (17'(i_first_pitch_angle)),
        .o_sin (w_s1),
        .o_cos (w_c1)
    );

    fka_trig u_trig_p12 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (w_sum_ang),
        .o_sin (w_s12),
        .o_cos (w_c12)
    );

    // ------------------------------------------------------------------
    // arm: link products, planar sums, yaw projection, rounding
    // ------------------------------------------------------------------
    always_comb begin
        // z: round half away from zero to whole units, then add the base link
        w_zmag = r_zs[SW-1] ? (SW+1)'(-r_zs) : (SW+1)'(r_zs);
        w_zrnd = (w_zmag + ((SW+1)'(1) << (F - 1))) >> F;
        n_pz   = r_zs[SW-1] ? -OW'(w_zrnd) : OW'(w_zrnd);

        // x and y carry twice the trig fraction bits
        w_xmag = r_px[QW-1] ? (QW+1)'(-r_px) : (QW+1)'(r_px);
        w_ymag = r_py[QW-1] ? (QW+1)'(-r_py) : (QW+1)'(r_py);
        w_xrnd = (w_xmag + ((QW+1)'(1) << (2 * F - 1))) >> (2 * F);
        w_yrnd = (w_ymag + ((QW+1)'(1) << (2 * F - 1))) >> (2 * F);
        n_out_x = r_px[QW-1] ? -OW'(w_xrnd) : OW'(w_xrnd);
        n_out_y = r_py[QW-1] ? -OW'(w_yrnd) : OW'(w_yrnd);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // link times trig
            r_m1   <= $signed({1'b0, r_len2}) * w_s1;
            r_m2   <= $signed({1'b0, r_len3}) * w_s12;
            r_m3   <= $signed({1'b0, r_len2}) * w_c1;
            r_m4   <= $signed({1'b0, r_len3}) * w_c12;
            r_sy_a <= w_sy;
            r_cy_a <= w_cy;
            // planar reach and height
            r_r    <= SW'(r_m1) + SW'(r_m2);
            r_zs   <= SW'(r_m3) + SW'(r_m4);
            r_sy_b <= r_sy_a;
            r_cy_b <= r_cy_a;
            // rotate the reach about the base
            r_px   <= QW'(r_r) * QW'(r_cy_b);
            r_py   <= QW'(r_r) * QW'(r_sy_b);
            r_pz   <= OW'(r_len1) + n_pz;
            // output register
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
            r_out_z <= r_pz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_pos_z     = r_out_z;

endmodule
`default_nettype wire

// File: src/fka_horner_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fka_horner_cell
// one horner step t' = 1 - ((x2*t) >> 30) / d in Q30, three stages deep
// ----------------------------------------------------------------------------
module fka_horner_cell (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [29:0] i_x2,
    input  wire logic [30:0] i_t,
    input  wire logic [30:0] i_mult,
    input  wire logic [5:0]  i_shift,
    output logic      [29:0] o_x2,
    output logic      [30:0] o_t
);

    logic [60:0] r_prod, n_prod;
    logic [60:0] r_quo, n_quo;
    logic [30:0] r_t, n_t;
    logic [29:0] r_x2_a, r_x2_b, r_x2_c;
    logic [29:0] w_v;
    logic [29:0] w_q;

    always_comb begin
        n_prod = 61'(i_x2) * 61'(i_t);
        w_v    = r_prod[59:30];
        n_quo  = 61'(w_v) * 61'(i_mult);
        w_q    = 30'(r_quo >> i_shift);
        n_t    = fka_pkg::Q30_ONE - 31'(w_q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_x2_a <= i_x2;
            r_quo  <= n_quo;
            r_x2_b <= r_x2_a;
            r_t    <= n_t;
            r_x2_c <= r_x2_b;
        end
    end

    assign o_x2 = r_x2_c;
    assign o_t  = r_t;

endmodule
`default_nettype wire

// File: src/fka_trig.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fka_trig
// pipelined sine and cosine of an angle in 1/128 degree units
// ----------------------------------------------------------------------------
module fka_trig (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [16:0]                  i_ang,
    output logic signed [fka_pkg::TRIG_BITS-1:0]     o_sin,
    output logic signed [fka_pkg::TRIG_BITS-1:0]     o_cos
);

    localparam int TB = fka_pkg::TRIG_BITS;
    localparam int NC = fka_pkg::NUM_CELLS;

    // stage 1: wrap to one turn
    logic [17:0] w_off, w_m1, w_m2;
    logic [15:0] r_u;
    // stage 2: quadrant and octant fold
    logic [1:0]  r_quad2, n_quad2;
    logic        r_swap2, n_swap2;
    logic [12:0] r_a, n_a;
    logic [13:0] w_rem;
    // stage 3: radians
    logic [50:0] w_rad;
    logic [29:0] r_x;
    logic        r_swap3;
    logic [1:0]  r_quad3;
    // stage 4: square
    logic [59:0] w_sq;
    logic [29:0] r_x2;
    fka_pkg::t_trig_aux r_aux [fka_pkg::AUX_DLY];
    // cell chain
    logic [29:0] w_x2 [NC];
    logic [30:0] w_ct [NC];
    logic [30:0] w_st [NC];
    // tail
    logic [60:0] r_sprod;
    logic [30:0] r_ct;
    logic        r_swap_f;
    logic [1:0]  r_quad_f;
    logic [31:0] w_srnd, w_crnd;
    logic [TB-1:0] w_smag, w_cmag, w_s, w_c;
    logic signed [TB-1:0] r_sin, r_cos, n_sin, n_cos;

    always_comb begin
        w_off = 18'({{2{i_ang[16]}}, i_ang} + 19'(2 * fka_pkg::FULL_TURN));
        w_m1  = (w_off >= 18'(2 * fka_pkg::FULL_TURN)) ?
                w_off - 18'(2 * fka_pkg::FULL_TURN) : w_off;
        w_m2  = (w_m1 >= 18'(fka_pkg::FULL_TURN)) ? w_m1 - 18'(fka_pkg::FULL_TURN) : w_m1;
    end

    always_comb begin
        if (r_u >= 16'(3 * fka_pkg::QUARTER_TURN)) begin
            n_quad2 = 2'd3;
            w_rem   = 14'(r_u - 16'(3 * fka_pkg::QUARTER_TURN));
        end else if (r_u >= 16'(2 * fka_pkg::QUARTER_TURN)) begin
            n_quad2 = 2'd2;
            w_rem   = 14'(r_u - 16'(2 * fka_pkg::QUARTER_TURN));
        end else if (r_u >= 16'(fka_pkg::QUARTER_TURN)) begin
            n_quad2 = 2'd1;
            w_rem   = 14'(r_u - 16'(fka_pkg::QUARTER_TURN));
        end else begin
            n_quad2 = 2'd0;
            w_rem   = 14'(r_u);
        end
        if (w_rem <= 14'(fka_pkg::EIGHTH_TURN)) begin
            n_swap2 = 1'b0;
            n_a     = 13'(w_rem);
        end else begin
            n_swap2 = 1'b1;
            n_a     = 13'(14'(fka_pkg::QUARTER_TURN) - w_rem);
        end
    end

    assign w_rad = 51'(r_a) * 51'(fka_pkg::RAD_K50) + fka_pkg::RAD_HALF;
    assign w_sq  = 60'(r_x) * 60'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u     <= w_m2[15:0];
            r_quad2 <= n_quad2;
            r_swap2 <= n_swap2;
            r_a     <= n_a;
            r_x     <= w_rad[49:20];
            r_swap3 <= r_swap2;
            r_quad3 <= r_quad2;
            r_x2    <= w_sq[59:30];
            r_aux[0] <= '{x: r_x, swap: r_swap3, quad: r_quad3};
            for (int k = 1; k < fka_pkg::AUX_DLY; k++) begin
                r_aux[k] <= r_aux[k-1];
            end
        end
    end

    // cosine chain runs six cells, sine chain joins at the second cell
    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            if (g == 0) begin : g_first
                fka_horner_cell u_cos (
                    .i_clk   (i_clk),
                    .i_en    (i_en),
                    .i_x2    (r_x2),
                    .i_t     (fka_pkg::Q30_ONE),
                    .i_mult  (fka_pkg::COS_MULT[g]),
                    .i_shift (fka_pkg::COS_SHIFT[g]),
                    .o_x2    (w_x2[g]),
                    .o_t     (w_ct[g])
                );
                assign w_st[g] = fka_pkg::Q30_ONE;
            end else begin : g_rest
                fka_horner_cell u_cos (
                    .i_clk   (i_clk),
                    .i_en    (i_en),
                    .i_x2    (w_x2[g-1]),
                    .i_t     (w_ct[g-1]),
                    .i_mult  (fka_pkg::COS_MULT[g]),
                    .i_shift (fka_pkg::COS_SHIFT[g]),
                    .o_x2    (w_x2[g]),
                    .o_t     (w_ct[g])
                );
                fka_horner_cell u_sin (
                    .i_clk   (i_clk),
                    .i_en    (i_en),
                    .i_x2    (w_x2[g-1]),
                    .i_t     (w_st[g-1]),
                    .i_mult  (fka_pkg::SIN_MULT[g]),
                    .i_shift (fka_pkg::SIN_SHIFT[g]),
                    .o_x2    (),
                    .o_t     (w_st[g])
                );
            end
        end
    endgenerate

    always_comb begin
        w_srnd = (32'(r_sprod[60:30]) + fka_pkg::RND_HALF) >> fka_pkg::RND_SH;
        w_crnd = (32'(r_ct) + fka_pkg::RND_HALF) >> fka_pkg::RND_SH;
        w_smag = (w_srnd > fka_pkg::TRIG_MAX) ? TB'(fka_pkg::TRIG_MAX) : TB'(w_srnd);
        w_cmag = (w_crnd > fka_pkg::TRIG_MAX) ? TB'(fka_pkg::TRIG_MAX) : TB'(w_crnd);
        w_s    = r_swap_f ? w_cmag : w_smag;
        w_c    = r_swap_f ? w_smag : w_cmag;
        case (r_quad_f)
            2'd0: begin
                n_sin = w_s;
                n_cos = w_c;
            end
            2'd1: begin
                n_sin = w_c;
                n_cos = -w_s;
            end
            2'd2: begin
                n_sin = -w_s;
                n_cos = -w_c;
            end
            default: begin
                n_sin = -w_c;
                n_cos = w_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sprod  <= 61'(r_aux[fka_pkg::AUX_DLY-1].x) * 61'(w_st[NC-1]);
            r_ct     <= w_ct[NC-1];
            r_swap_f <= r_aux[fka_pkg::AUX_DLY-1].swap;
            r_quad_f <= r_aux[fka_pkg::AUX_DLY-1].quad;
            r_sin    <= n_sin;
            r_cos    <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

// File: bench/three_joint_arm_forward_kinematics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_joint_arm_forward_kinematics_tb
// drives joint angle transactions with random gaps and output stalls,
// predicts each position with an integer series model of the trig path and
// compares every field, across several link length settings
// ----------------------------------------------------------------------------
module three_joint_arm_forward_kinematics_tb;

    localparam int LATENCY   = 27;
    localparam int WDOG_MAX  = 5000;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
    } t_angles;

    typedef struct packed {
        logic signed [18:0] x;
        logic signed [18:0] y;
        logic signed [18:0] z;
    } t_pos;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_yaw_angle = '0;
    logic signed [15:0] i_first_pitch_angle = '0;
    logic signed [15:0] i_second_pitch_angle = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [18:0] o_pos_x, o_pos_y, o_pos_z;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    three_joint_arm_forward_kinematics DUT (.*);

    // clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // link lengths as the predictor sees them
    logic [15:0] link1 = fka_pkg::LINK_RESET;
    logic [15:0] link2 = fka_pkg::LINK_RESET;
    logic [15:0] link3 = fka_pkg::LINK_RESET;

    t_angles angle_queue[$];   // transactions waiting for the driver
    t_pos    pos_queue[$];     // predicted positions, oldest first
    int      errors = 0;
    int      n_checked = 0;
    int      n_sent = 0;
    bit      calm = 1'b0;      // no idling in the last part
    bit      hold_long = 1'b0; // request for a long output stall

    // sin and cos magnitudes with FRAC fraction bits, a in [0, eighth turn]
    function automatic void octant_sc(input int unsigned a,
                                      output longint unsigned sv,
                                      output longint unsigned cv);
        longint unsigned xr, x2, t, q;
        int unsigned sdiv[5] = '{110, 72, 42, 20, 6};
        int unsigned cdiv[6] = '{132, 90, 56, 30, 12, 2};
        longint unsigned lim;
        lim = (64'd1 << fka_pkg::FRAC) - 1;
        xr = (64'(a) * 64'd153520784550 + (64'd1 << 19)) >> 20;
        x2 = (xr * xr) >> 30;
        t = 64'd1 << 30;
        foreach (sdiv[i]) t = (64'd1 << 30) - ((x2 * t) >> 30) / sdiv[i];
        q = (((xr * t) >> 30) + (64'd1 << (fka_pkg::RND_SH - 1))) >> fka_pkg::RND_SH;
        sv = q > lim ? lim : q;
        t = 64'd1 << 30;
        foreach (cdiv[i]) t = (64'd1 << 30) - ((x2 * t) >> 30) / cdiv[i];
        q = (t + (64'd1 << (fka_pkg::RND_SH - 1))) >> fka_pkg::RND_SH;
        cv = q > lim ? lim : q;
    endfunction

    // signed sin and cos of an angle in 1/128 degree, wrapped to a full turn
    function automatic void angle_sc(input int ang, output longint s, output longint c);
        int m;
        int unsigned u, q, r;
        longint unsigned sv, cv;
        m = ang % fka_pkg::FULL_TURN;
        if (m < 0) m += fka_pkg::FULL_TURN;
        u = m;
        q = u / fka_pkg::QUARTER_TURN;
        r = u % fka_pkg::QUARTER_TURN;
        if (r <= fka_pkg::EIGHTH_TURN) octant_sc(r, sv, cv);
        else octant_sc(fka_pkg::QUARTER_TURN - r, cv, sv);
        case (q)
            0: begin s = sv;  c = cv;  end
            1: begin s = cv;  c = -sv; end
            2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
    endfunction

    function automatic longint round_half_away(input longint v, input int sh);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return v < 0 ? -m : m;
    endfunction

    function automatic t_pos arm_position(input t_angles a);
        longint sy, cy, s1, c1, s12, c12, r, zs;
        t_pos p;
        angle_sc(a.yaw, sy, cy);
        angle_sc(a.p1, s1, c1);
        angle_sc(int'(a.p1) + int'(a.p2), s12, c12);
        r  = longint'(link2) * s1 + longint'(link3) * s12;
        zs = longint'(link2) * c1 + longint'(link3) * c12;
        p.x = 19'(round_half_away(r * cy, 2 * fka_pkg::FRAC));
        p.y = 19'(round_half_away(r * sy, 2 * fka_pkg::FRAC));
        p.z = 19'(longint'(link1) + round_half_away(zs, fka_pkg::FRAC));
        return p;
    endfunction

    // driver: feeds angle transactions, random idle bursts
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pos_queue.push_back(arm_position({i_yaw_angle, i_first_pitch_angle,
                                                  i_second_pitch_angle}));
                n_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (angle_queue.size() > 0) begin
                    {i_yaw_angle, i_first_pitch_angle, i_second_pitch_angle}
                        <= angle_queue.pop_front();
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random output stalls, field by field compare
    int out_gap = 0;
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pos_queue.size() == 0) begin
                    $display("%0t: position transaction with nothing expected", $time);
                    errors++;
                end else begin
                    t_pos e;
                    e = pos_queue.pop_front();
                    n_checked++;
                    if (o_pos_x !== e.x) begin
                        $display("%0t: pos_x expected %0d actual %0d", $time, e.x, o_pos_x);
                        errors++;
                    end
                    if (o_pos_y !== e.y) begin
                        $display("%0t: pos_y expected %0d actual %0d", $time, e.y, o_pos_y);
                        errors++;
                    end
                    if (o_pos_z !== e.z) begin
                        $display("%0t: pos_z expected %0d actual %0d", $time, e.z, o_pos_z);
                        errors++;
                    end
                end
            end
            // long hold-off so the pipeline fills and backs up the input
            if (hold_long && hold_cnt == 0) hold_cnt <= 120;
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 7);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel and no register access
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else if (angle_queue.size() > 0 || pos_queue.size() > 0 || i_in_valid)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("FAIL three_joint_arm_forward_kinematics");
            $finish;
        end
    end

    // register write, setup then access
    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= {16'(~val), val};  // upper bits ignored
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            fka_pkg::REG_FIRST_LINK:  link1 = val;
            fka_pkg::REG_SECOND_LINK: link2 = val;
            default:                  link3 = val;
        endcase
    endtask

    task automatic drain();
        wait (angle_queue.size() == 0 && !i_in_valid && pos_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 46080) - 23040);
            1: return 16'($urandom());   // any code, wraps
            2: return 16'(int'($urandom_range(0, 8)) * 2880 - 11520 +
                          int'($urandom_range(0, 2)) - 1);
            default: return 16'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    task automatic push_random(input int n);
        repeat (n) angle_queue.push_back({rand_angle(), rand_angle(), rand_angle()});
    endtask

    initial begin
        logic signed [15:0] edges[10] = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520,
            -16'sd11520, 16'sd5760, 16'sd5761, 16'sh7fff, -16'sh8000, 16'sd1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset lengths, extremes, octant edges and wraps
        foreach (edges[i]) angle_queue.push_back({edges[i], edges[i], edges[(i + 3) % 10]});
        angle_queue.push_back({16'sd5760, 16'sd23040, 16'sd23040});  // joint sum wraps
        angle_queue.push_back({-16'sd5760, -16'sd23040, -16'sd23040});
        angle_queue.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff});
        angle_queue.push_back({-16'sh8000, -16'sh8000, -16'sh8000});
        angle_queue.push_back({16'sd0, 16'sd0, 16'sd0});              // unity cos
        drain();

        // maximum links, every bit set
        reg_write(fka_pkg::REG_FIRST_LINK, 16'hffff);
        reg_write(fka_pkg::REG_SECOND_LINK, 16'hffff);
        reg_write(fka_pkg::REG_THIRD_LINK, 16'hffff);
        angle_queue.push_back({16'sd0, 16'sd0, 16'sd0});
        angle_queue.push_back({16'sd11520, 16'sd11520, 16'sd0});
        angle_queue.push_back({-16'sd23040, -16'sd11520, -16'sd0});
        push_random(100);
        hold_long = 1'b1;
        wait (hold_cnt > 0);
        hold_long = 1'b0;
        drain();

        // zero links
        reg_write(fka_pkg::REG_FIRST_LINK, 16'h0000);
        reg_write(fka_pkg::REG_SECOND_LINK, 16'h0000);
        reg_write(fka_pkg::REG_THIRD_LINK, 16'h0000);
        push_random(40);
        drain();

        // random lengths, several phases
        repeat (4) begin
            reg_write(fka_pkg::REG_FIRST_LINK, 16'($urandom()));
            reg_write(fka_pkg::REG_SECOND_LINK, 16'($urandom()));
            reg_write(fka_pkg::REG_THIRD_LINK, 16'($urandom()));
            push_random(80);
            drain();
        end

        // last part with no idling
        reg_write(fka_pkg::REG_SECOND_LINK, 16'h5555);
        reg_write(fka_pkg::REG_THIRD_LINK, 16'haaaa);
        calm = 1'b1;
        push_random(40);
        drain();

        $display("covered %0d angle transactions, %0d positions checked, link settings",
                 n_sent, n_checked);
        $display("  from zero to full scale with long and random output stalls");
        if (errors == 0)
            $display("PASS three_joint_arm_forward_kinematics");
        else
            $display("FAIL three_joint_arm_forward_kinematics");
        $finish;
    end
endmodule
